FILE: rtl/stse_pkg.sv
// Shared types, codes and constants of the sensor telemetry slot encoder.
// Used by the serial arithmetic unit and the top level.
package stse_pkg;

   // Configuration port
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;

   // Register indexes (byte address divided by four)
   localparam logic [2:0] REG_CURRENT_SLOT     = 3'd0;
   localparam logic [2:0] REG_TEMPERATURE_SLOT = 3'd1;
   localparam logic [2:0] REG_RPM_SLOT         = 3'd2;
   localparam logic [2:0] REG_ALARM_SLOT       = 3'd3;
   localparam logic [2:0] REG_CAPACITY_GAIN    = 3'd4;

   localparam logic [7:0] CAPACITY_GAIN_RESET = 8'd100;

   // Serial arithmetic unit
   localparam int DATA_WIDTH  = 32;
   localparam int MPLIER_WIDTH = 20;
   localparam int DVS_WIDTH   = 12;
   localparam int STEP_WIDTH  = 6;

   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   // Scaling constants
   localparam logic [DVS_WIDTH-1:0]    DIV_TEN      = 12'd10;
   localparam logic [DVS_WIDTH-1:0]    DIV_HUNDRED  = 12'd100;
   localparam logic [DVS_WIDTH-1:0]    DIV_THOUSAND = 12'd1000;
   localparam logic [DVS_WIDTH-1:0]    DIV_HOUR     = 12'd3600;
   localparam logic [DVS_WIDTH-1:0]    DIV_SIX      = 12'd6;
   localparam logic [MPLIER_WIDTH-1:0] MUL_CURRENT  = 20'd117;
   localparam logic [MPLIER_WIDTH-1:0] MUL_VOLTAGE  = 20'd105;

   // Telemetry frame bytes
   localparam logic [7:0]  TYPE_STATUS  = 8'h13;
   localparam logic [7:0]  TYPE_POWER   = 8'h03;
   localparam logic [15:0] VALUE_MARK   = 16'h4000;
   localparam logic [13:0] CURRENT_MAX  = 14'h3FFF;
   localparam logic [7:0]  CURRENT_HI_SET  = 8'h40;
   localparam logic [7:0]  CURRENT_HI_MASK = 8'h7F;
   localparam logic [10:0] ALARM_FAILSAFE  = 11'd1000;
   localparam logic [10:0] ALARM_LOST      = 11'd100;

   typedef struct packed {
      logic                    start;
      logic                    op;
      logic [STEP_WIDTH-1:0]   steps;
      logic [DATA_WIDTH-1:0]   opa;
      logic [MPLIER_WIDTH-1:0] opb;
   } arith_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_sts_type;

   // Divide a left-aligned dividend of 'steps' bits by a constant
   function automatic arith_cmd_type arith_div(logic [DATA_WIDTH-1:0] dvd,
                                               logic [DVS_WIDTH-1:0] dvs,
                                               logic [STEP_WIDTH-1:0] steps);
      arith_cmd_type c;
      c.start = 1'b1;
      c.op    = OP_DIV;
      c.steps = steps;
      c.opa   = dvd;
      c.opb   = {{(MPLIER_WIDTH-DVS_WIDTH){1'b0}}, dvs};
      return c;
   endfunction

   // Multiply, one multiplier bit per step, product kept to DATA_WIDTH bits
   function automatic arith_cmd_type arith_mul(logic [DATA_WIDTH-1:0] mcand,
                                               logic [MPLIER_WIDTH-1:0] mplier,
                                               logic [STEP_WIDTH-1:0] steps);
      arith_cmd_type c;
      c.start = 1'b1;
      c.op    = OP_MUL;
      c.steps = steps;
      c.opa   = mcand;
      c.opb   = mplier;
      return c;
   endfunction

endpackage

FILE: rtl/stse_req_if.sv
// Request channel of the sensor telemetry slot encoder: one servo-frame event per beat.
// Plain valid/ready handshake; no package dependency.
interface stse_req_if;
   logic               valid;
   logic               ready;
   logic               channel_valid;
   logic [31:0]        timestamp_ms;
   logic [19:0]        motor_current;
   logic [19:0]        voltage_raw;
   logic signed [15:0] temperature;
   logic [15:0]        rpm;
   logic               failsafe;
   logic               frame_lost;
   logic               uart_dropped;

   modport source (
      output valid, channel_valid, timestamp_ms, motor_current, voltage_raw,
             temperature, rpm, failsafe, frame_lost, uart_dropped,
      input  ready
   );

   modport sink (
      input  valid, channel_valid, timestamp_ms, motor_current, voltage_raw,
             temperature, rpm, failsafe, frame_lost, uart_dropped,
      output ready
   );
endinterface

FILE: rtl/stse_rsp_if.sv
// Result channel of the sensor telemetry slot encoder: one 3-byte slot frame per beat.
// Plain valid/ready handshake; no package dependency.
interface stse_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] slot;
   logic [7:0] byte_zero;
   logic [7:0] byte_one;
   logic [7:0] byte_two;
   logic       last;

   modport source (
      output valid, slot, byte_zero, byte_one, byte_two, last,
      input  ready
   );

   modport sink (
      input  valid, slot, byte_zero, byte_one, byte_two, last,
      output ready
   );
endinterface

FILE: rtl/stse_serial_alu.sv
// Bit-serial multiply / constant-divide unit: one multiplier bit or one quotient bit a cycle.
// Depends on stse_pkg for the command and status types.
module stse_serial_alu (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stse_pkg::arith_cmd_type              cmd,
   output stse_pkg::arith_sts_type              sts,
   output logic [stse_pkg::DATA_WIDTH-1:0]      result
);
   import stse_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_WIDTH-1:0]   count_ff, count_in;
   logic                    op_ff;
   logic [DATA_WIDTH-1:0]   shift_ff;   // multiplicand, or dividend turning into quotient
   logic [DATA_WIDTH-1:0]   acc_ff;     // product
   logic [MPLIER_WIDTH-1:0] opb_ff;     // multiplier, or divisor in the low bits
   logic [DVS_WIDTH-1:0]    rem_ff;     // partial remainder

   logic                    last_step;
   logic [DVS_WIDTH:0]      rem_sh;
   logic [DVS_WIDTH:0]      rem_diff;
   logic                    rem_ge;

   assign last_step = busy_ff && (count_ff == {{(STEP_WIDTH-1){1'b0}}, 1'b1});

   // Restoring division step
   assign rem_sh   = {rem_ff, shift_ff[DATA_WIDTH-1]};
   assign rem_ge   = rem_sh >= {1'b0, opb_ff[DVS_WIDTH-1:0]};
   assign rem_diff = rem_sh - {1'b0, opb_ff[DVS_WIDTH-1:0]};

   // Sequence control
   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      done_in  = last_step;
      if (cmd.start) begin
         busy_in  = 1'b1;
         count_in = cmd.steps;
      end else if (busy_ff) begin
         count_in = count_ff - {{(STEP_WIDTH-1){1'b0}}, 1'b1};
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Load operands, then advance one bit a cycle
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff    <= cmd.op;
         shift_ff <= cmd.opa;
         opb_ff   <= cmd.opb;
         acc_ff   <= '0;
         rem_ff   <= '0;
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            rem_ff   <= rem_ge ? rem_diff[DVS_WIDTH-1:0] : rem_sh[DVS_WIDTH-1:0];
            shift_ff <= {shift_ff[DATA_WIDTH-2:0], rem_ge};
         end else begin
            if (opb_ff[0]) begin
               acc_ff <= acc_ff + shift_ff;
            end
            shift_ff <= {shift_ff[DATA_WIDTH-2:0], 1'b0};
            opb_ff   <= {1'b0, opb_ff[MPLIER_WIDTH-1:1]};
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result   = (op_ff == OP_DIV) ? shift_ff : acc_ff;

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("serial alu started while busy");

   a_steps_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> (cmd.steps != '0))
      else $error("serial alu started with no steps");

   a_done_after_last: assert property (@(posedge clock) disable iff (reset)
      (last_step && !cmd.start) |=> (done_ff && !busy_ff))
      else $error("serial alu did not finish after its last step");
`endif

endmodule

FILE: rtl/sensor_telemetry_slot_encoder.sv
// Top level of the sensor telemetry slot encoder: APB register block, event sequencer and
// slot frame output register. Depends on stse_pkg, stse_req_if, stse_rsp_if, stse_serial_alu.
//
// Each valid event beat is turned into five or six 3-byte slot frames: alarm (when the alarm
// slot is nonzero), temperature, current, voltage, capacity and rpm, the last one flagged.
// All scaling runs through one bit-serial multiply/divide unit that handles one bit a cycle:
// twelve operations of 7 to 32 steps each, one after another, then one frame per cycle
// while the result side takes beats. An event with channel_valid low is taken and gives
// nothing. A new event is taken once the final frame sits in the output register. The used
// charge integrates current times elapsed milliseconds over 3600 with 32-bit wraparound.
module sensor_telemetry_slot_encoder (
   input  logic                                clock,
   input  logic                                reset,
   stse_req_if.sink                            req_bus,
   stse_rsp_if.source                          rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [stse_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [stse_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [stse_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);
   import stse_pkg::*;

   // Sequencer states: one per arithmetic operation, then frame output
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CDIV10  = 4'd1;
   localparam logic [3:0] S_CMUL    = 4'd2;
   localparam logic [3:0] S_CDIV100 = 4'd3;
   localparam logic [3:0] S_VDIV10  = 4'd4;
   localparam logic [3:0] S_VMUL    = 4'd5;
   localparam logic [3:0] S_VDIV100 = 4'd6;
   localparam logic [3:0] S_PMUL    = 4'd7;
   localparam logic [3:0] S_PDIV    = 4'd8;
   localparam logic [3:0] S_UDIV    = 4'd9;
   localparam logic [3:0] S_GMUL    = 4'd10;
   localparam logic [3:0] S_GDIV    = 4'd11;
   localparam logic [3:0] S_RDIV    = 4'd12;
   localparam logic [3:0] S_EMIT    = 4'd13;

   // Frame order within an event
   localparam logic [2:0] FRAME_ALARM    = 3'd0;
   localparam logic [2:0] FRAME_TEMP     = 3'd1;
   localparam logic [2:0] FRAME_CURRENT  = 3'd2;
   localparam logic [2:0] FRAME_VOLTAGE  = 3'd3;
   localparam logic [2:0] FRAME_CAPACITY = 3'd4;
   localparam logic [2:0] FRAME_RPM      = 3'd5;

   // Configuration registers
   logic [4:0] current_slot_ff;
   logic [4:0] temperature_slot_ff;
   logic [4:0] rpm_slot_ff;
   logic [4:0] alarm_slot_ff;
   logic [7:0] capacity_gain_ff;

   // Event state
   logic [31:0] reference_time_ff;
   logic [31:0] used_charge_ff;

   // Captured event fields and scaled values
   logic [31:0] timestamp_ff;
   logic [19:0] motor_current_ff;
   logic [19:0] voltage_raw_ff;
   logic [15:0] temperature_ff;
   logic [15:0] rpm_raw_ff;
   logic        failsafe_ff;
   logic        frame_lost_ff;
   logic        uart_dropped_ff;
   logic [13:0] current_val_ff;
   logic [15:0] voltage_val_ff;
   logic [15:0] capacity_val_ff;
   logic [15:0] rpm_val_ff;

   // Sequencer and output register
   logic [3:0]  state_ff, state_in;
   logic [2:0]  frame_ff, frame_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  rsp_slot_ff;
   logic [7:0]  rsp_byte_zero_ff;
   logic [7:0]  rsp_byte_one_ff;
   logic [7:0]  rsp_byte_two_ff;
   logic        rsp_last_ff;

   arith_cmd_type              arith_cmd;
   arith_sts_type              arith_sts;
   logic [DATA_WIDTH-1:0]      arith_res;

   logic        csr_write;
   logic        req_take;
   logic        emit_load;
   logic [31:0] elapsed;
   logic [31:0] used_sum;
   logic [10:0] alarm_sum;
   logic [15:0] alarm_val;
   logic [15:0] temp_val;
   logic [15:0] current_full;
   logic [2:0]  first_frame;

   logic [4:0]  frm_slot;
   logic [7:0]  frm_byte_zero;
   logic [7:0]  frm_byte_one;
   logic [7:0]  frm_byte_two;
   logic        frm_last;

   stse_serial_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (arith_cmd),
      .sts    (arith_sts),
      .result (arith_res)
   );

   // Register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         current_slot_ff     <= '0;
         temperature_slot_ff <= '0;
         rpm_slot_ff         <= '0;
         alarm_slot_ff       <= '0;
         capacity_gain_ff    <= CAPACITY_GAIN_RESET;
      end else if (csr_write) begin
         case (paddr[4:2])
            REG_CURRENT_SLOT:     current_slot_ff     <= pwdata[4:0];
            REG_TEMPERATURE_SLOT: temperature_slot_ff <= pwdata[4:0];
            REG_RPM_SLOT:         rpm_slot_ff         <= pwdata[4:0];
            REG_ALARM_SLOT:       alarm_slot_ff       <= pwdata[4:0];
            REG_CAPACITY_GAIN:    capacity_gain_ff    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_CURRENT_SLOT:     prdata = {27'd0, current_slot_ff};
         REG_TEMPERATURE_SLOT: prdata = {27'd0, temperature_slot_ff};
         REG_RPM_SLOT:         prdata = {27'd0, rpm_slot_ff};
         REG_ALARM_SLOT:       prdata = {27'd0, alarm_slot_ff};
         REG_CAPACITY_GAIN:    prdata = {24'd0, capacity_gain_ff};
         default:              prdata = '0;
      endcase
   end

   // Handshakes
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && (state_ff == S_IDLE) && req_bus.channel_valid;
   assign emit_load     = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_bus.ready);

   assign elapsed     = timestamp_ff - reference_time_ff;
   assign used_sum    = used_charge_ff + arith_res;
   assign first_frame = (alarm_slot_ff != 5'd0) ? FRAME_ALARM : FRAME_TEMP;

   // Sequence the operations; each starts as the one before finishes
   always_comb begin
      state_in  = state_ff;
      frame_in  = frame_ff;
      arith_cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in  = S_CDIV10;
               arith_cmd = arith_div({req_bus.motor_current, 12'd0}, DIV_TEN, 6'd20);
            end
         end
         S_CDIV10: begin
            if (arith_sts.done) begin
               state_in  = S_CMUL;
               arith_cmd = arith_mul({16'd0, arith_res[15:0]}, MUL_CURRENT, 6'd7);
            end
         end
         S_CMUL: begin
            if (arith_sts.done) begin
               state_in  = S_CDIV100;
               arith_cmd = arith_div({arith_res[22:0], 9'd0}, DIV_HUNDRED, 6'd23);
            end
         end
         S_CDIV100: begin
            if (arith_sts.done) begin
               state_in  = S_VDIV10;
               arith_cmd = arith_div({voltage_raw_ff, 12'd0}, DIV_TEN, 6'd20);
            end
         end
         S_VDIV10: begin
            if (arith_sts.done) begin
               state_in  = S_VMUL;
               arith_cmd = arith_mul({16'd0, arith_res[15:0]}, MUL_VOLTAGE, 6'd7);
            end
         end
         S_VMUL: begin
            if (arith_sts.done) begin
               state_in  = S_VDIV100;
               arith_cmd = arith_div({arith_res[22:0], 9'd0}, DIV_HUNDRED, 6'd23);
            end
         end
         S_VDIV100: begin
            if (arith_sts.done) begin
               state_in  = S_PMUL;
               arith_cmd = arith_mul(elapsed, motor_current_ff, 6'd20);
            end
         end
         S_PMUL: begin
            if (arith_sts.done) begin
               state_in  = S_PDIV;
               arith_cmd = arith_div(arith_res, DIV_HOUR, 6'd32);
            end
         end
         S_PDIV: begin
            if (arith_sts.done) begin
               state_in  = S_UDIV;
               arith_cmd = arith_div(used_sum, DIV_THOUSAND, 6'd32);
            end
         end
         S_UDIV: begin
            if (arith_sts.done) begin
               state_in  = S_GMUL;
               arith_cmd = arith_mul({16'd0, arith_res[15:0]},
                                     {12'd0, capacity_gain_ff}, 6'd8);
            end
         end
         S_GMUL: begin
            if (arith_sts.done) begin
               state_in  = S_GDIV;
               arith_cmd = arith_div({arith_res[23:0], 8'd0}, DIV_HUNDRED, 6'd24);
            end
         end
         S_GDIV: begin
            if (arith_sts.done) begin
               state_in  = S_RDIV;
               arith_cmd = arith_div({rpm_raw_ff, 16'd0}, DIV_SIX, 6'd16);
            end
         end
         S_RDIV: begin
            if (arith_sts.done) begin
               state_in = S_EMIT;
               frame_in = first_frame;
            end
         end
         S_EMIT: begin
            if (emit_load) begin
               frame_in = frame_ff + 3'd1;
               if (frame_ff == FRAME_RPM) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         frame_ff          <= FRAME_ALARM;
         reference_time_ff <= '0;
         used_charge_ff    <= '0;
      end else begin
         state_ff <= state_in;
         frame_ff <= frame_in;
         // Advance the time reference as the elapsed time is handed to the multiplier
         if ((state_ff == S_VDIV100) && arith_sts.done) begin
            reference_time_ff <= timestamp_ff;
         end
         if ((state_ff == S_PDIV) && arith_sts.done) begin
            used_charge_ff <= used_sum;
         end
      end
   end

   // Capture event fields and scaled values
   assign current_full = arith_res[15:0];

   always_ff @(posedge clock) begin
      if (req_take) begin
         timestamp_ff     <= req_bus.timestamp_ms;
         motor_current_ff <= req_bus.motor_current;
         voltage_raw_ff   <= req_bus.voltage_raw;
         temperature_ff   <= req_bus.temperature;
         rpm_raw_ff       <= req_bus.rpm;
         failsafe_ff      <= req_bus.failsafe;
         frame_lost_ff    <= req_bus.frame_lost;
         uart_dropped_ff  <= req_bus.uart_dropped;
      end
      if (arith_sts.done) begin
         case (state_ff)
            S_CDIV100: current_val_ff  <= (current_full > {2'b00, CURRENT_MAX}) ?
                                          CURRENT_MAX : current_full[13:0];
            S_VDIV100: voltage_val_ff  <= arith_res[15:0];
            S_GDIV:    capacity_val_ff <= arith_res[15:0];
            S_RDIV:    rpm_val_ff      <= arith_res[15:0];
            default: ;
         endcase
      end
   end

   // Build the frame selected for output
   assign alarm_sum = (failsafe_ff ? ALARM_FAILSAFE : 11'd0)
                    + (frame_lost_ff ? ALARM_LOST : 11'd0)
                    + {10'd0, uart_dropped_ff};
   assign alarm_val = VALUE_MARK | {5'd0, alarm_sum};
   assign temp_val  = temperature_ff | VALUE_MARK;

   always_comb begin
      frm_slot      = temperature_slot_ff;
      frm_byte_zero = TYPE_STATUS;
      frm_byte_one  = temp_val[15:8];
      frm_byte_two  = temp_val[7:0];
      frm_last      = 1'b0;
      case (frame_ff)
         FRAME_ALARM: begin
            frm_slot     = alarm_slot_ff;
            frm_byte_one = alarm_val[15:8];
            frm_byte_two = alarm_val[7:0];
         end
         FRAME_TEMP: begin
            frm_slot = temperature_slot_ff;
         end
         FRAME_CURRENT: begin
            frm_slot      = current_slot_ff;
            frm_byte_zero = TYPE_POWER;
            frm_byte_one  = ({2'b00, current_val_ff[13:8]} | CURRENT_HI_SET) & CURRENT_HI_MASK;
            frm_byte_two  = current_val_ff[7:0];
         end
         FRAME_VOLTAGE: begin
            frm_slot      = current_slot_ff + 5'd1;
            frm_byte_zero = TYPE_POWER;
            frm_byte_one  = voltage_val_ff[15:8];
            frm_byte_two  = voltage_val_ff[7:0];
         end
         FRAME_CAPACITY: begin
            frm_slot      = current_slot_ff + 5'd2;
            frm_byte_zero = TYPE_POWER;
            frm_byte_one  = capacity_val_ff[15:8];
            frm_byte_two  = capacity_val_ff[7:0];
         end
         FRAME_RPM: begin
            frm_slot      = rpm_slot_ff;
            frm_byte_one  = rpm_val_ff[7:0];
            frm_byte_two  = rpm_val_ff[15:8];
            frm_last      = 1'b1;
         end
         default: ;
      endcase
   end

   // Output register: load a frame when empty or when the held beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_slot_ff      <= frm_slot;
         rsp_byte_zero_ff <= frm_byte_zero;
         rsp_byte_one_ff  <= frm_byte_one;
         rsp_byte_two_ff  <= frm_byte_two;
         rsp_last_ff      <= frm_last;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.slot      = rsp_slot_ff;
   assign rsp_bus.byte_zero = rsp_byte_zero_ff;
   assign rsp_bus.byte_one  = rsp_byte_one_ff;
   assign rsp_bus.byte_two  = rsp_byte_two_ff;
   assign rsp_bus.last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_idle_alu_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !arith_sts.busy)
      else $error("serial alu busy while sequencer idle");

   a_done_in_compute: assert property (@(posedge clock) disable iff (reset)
      arith_sts.done |-> ((state_ff != S_IDLE) && (state_ff != S_EMIT)))
      else $error("serial alu result with no operation pending");

   a_emit_alu_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> !arith_sts.busy)
      else $error("serial alu busy during frame output");

   a_last_ends_event: assert property (@(posedge clock) disable iff (reset)
      (emit_load && (frame_ff == FRAME_RPM)) |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle after final frame");
`endif

endmodule
